### design/lrupr_pkg.sv
// Shared constants for the LRU page replacement block.
// No dependencies; imported by the store and the top level.
`default_nettype none

package lrupr_pkg;

   // Built depth and page width defaults.
   localparam int MAX_SLOTS_DEF  = 16;
   localparam int PAGE_WIDTH_DEF = 16;

   // Fixed port widths.
   localparam int PAGE_NUMBER_W = 16;
   localparam int FAULT_W       = 32;
   localparam int CSR_W         = 5;

   // Reset value of the slots-in-use register.
   localparam int CSR_RESET = 16;

endpackage

`default_nettype wire

### design/lrupr_store.sv
// Fully associative page store kept in LRU order, with per-slot valid marks.
// Depends on lrupr_pkg for its parameter defaults.
`default_nettype none

module lrupr_store #(
   parameter int MAX_SLOTS  = lrupr_pkg::MAX_SLOTS_DEF,
   parameter int PAGE_WIDTH = lrupr_pkg::PAGE_WIDTH_DEF,
   parameter int CNT_W      = $clog2(MAX_SLOTS + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  update,
   input  wire logic [PAGE_WIDTH-1:0] page,
   input  wire logic [CNT_W-1:0]      slots_used,
   output logic                       hit
);

   import lrupr_pkg::*;

   logic [PAGE_WIDTH-1:0] slot_ff [MAX_SLOTS];
   logic [PAGE_WIDTH-1:0] slot_in [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]  valid_ff;
   logic [MAX_SLOTS-1:0]  valid_in;
   logic [MAX_SLOTS:0]    valid_ext;

   logic [MAX_SLOTS-1:0] active;
   logic [MAX_SLOTS-1:0] stop;
   logic [MAX_SLOTS-1:0] hit_first;
   logic [MAX_SLOTS-1:0] empty_first;
   logic [MAX_SLOTS-1:0] start;
   logic [MAX_SLOTS-1:0] reach;
   logic [MAX_SLOTS-1:0] put;
   logic [MAX_SLOTS-1:0] shift;
   logic                 found_hit;
   logic                 found_empty;

   assign valid_ext = {1'b0, valid_ff};

   // Lookup: first matching valid slot and first empty slot among those in use.
   always_comb begin
      found_hit   = 1'b0;
      found_empty = 1'b0;
      hit_first   = '0;
      empty_first = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         active[i] = CNT_W'(i) < slots_used;
         // A run of valid entries ends at the last slot in use or before an empty one.
         stop[i]   = (CNT_W'(i + 1) == slots_used) || !valid_ext[i + 1];
         if (!found_hit && active[i] && valid_ff[i] && (slot_ff[i] == page)) begin
            hit_first[i] = 1'b1;
            found_hit    = 1'b1;
         end
         if (!found_empty && active[i] && !valid_ff[i]) begin
            empty_first[i] = 1'b1;
            found_empty    = 1'b1;
         end
      end
   end

   assign hit = found_hit;

   // A hit shifts from the hit slot; a miss into a full store shifts from slot 0.
   always_comb begin
      start = '0;
      if (found_hit) begin
         start = hit_first;
      end else if (!found_empty) begin
         start[0] = 1'b1;
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (i == 0) begin
            reach[i] = start[i];
         end else begin
            reach[i] = start[i] | (reach[i-1] & ~stop[i-1]);
         end
         shift[i] = reach[i] & ~stop[i];
         put[i]   = (reach[i] & stop[i]) | (~found_hit & empty_first[i]);
      end
   end

   for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_slot
      logic [PAGE_WIDTH-1:0] next_src;
      if (g < MAX_SLOTS - 1) begin : g_inner
         assign next_src = slot_ff[g+1];
      end else begin : g_last
         assign next_src = slot_ff[g];
      end

      always_comb begin
         slot_in[g]  = slot_ff[g];
         valid_in[g] = valid_ff[g];
         if (update) begin
            if (put[g]) begin
               slot_in[g]  = page;
               valid_in[g] = 1'b1;
            end else if (shift[g]) begin
               slot_in[g] = next_src;
            end
         end
      end

      always_ff @(posedge clock) begin
         slot_ff[g] <= slot_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Valid entries always form a prefix of the store.
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_ff + MAX_SLOTS'(1)) & valid_ff) == '0)
      else $error("valid slots do not form a prefix");

   // At most one slot takes the new page per reference.
   a_single_put: assert property (@(posedge clock) disable iff (reset)
      update |-> $onehot0(put))
      else $error("more than one slot written with the page");

   // A hit never changes how many slots are valid.
   a_hit_keeps_count: assert property (@(posedge clock) disable iff (reset)
      update && hit |=> $countones(valid_ff) == $past($countones(valid_ff)))
      else $error("valid count changed on a hit");

endmodule

`default_nettype wire

### design/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: handshakes, slot-count register
// and fault counter around lrupr_store. Depends on lrupr_pkg and lrupr_store.
`default_nettype none

// Each request word carries one page reference and produces exactly one response
// word: a hit flag and the running, saturating page fault total including this
// reference. The block sustains one reference per clock cycle while responses are
// taken. A reference is captured in an input register; once the output register
// can take the response, the whole slot store is searched in parallel, reordered
// by a one-place shift, and the response is loaded into the output register. A
// held-off response stalls the input once the input register is also occupied.
// That combinational compare and shift across all slots is what sets the clock
// rate of the design. Slots beyond the configured count are left untouched and
// rejoin with their old contents when the count is raised. A count of zero acts
// as one, and one above MAX_SLOTS acts as MAX_SLOTS. Write the count only while no
// reference is in flight. Pages wider than the request field are zero-extended;
// narrower ones use the low bits of the request.
module lru_page_replacement_top #(
   parameter int MAX_SLOTS  = lrupr_pkg::MAX_SLOTS_DEF,
   parameter int PAGE_WIDTH = lrupr_pkg::PAGE_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [lrupr_pkg::PAGE_NUMBER_W-1:0] req_page_number,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_hit,
   output logic [lrupr_pkg::FAULT_W-1:0]           rsp_fault_total,
   input  wire logic                               csr_write_enable,
   input  wire logic [lrupr_pkg::CSR_W-1:0]        csr_entries_in_use
);

   import lrupr_pkg::*;

   localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W       = ((CNT_W > CSR_W) ? CNT_W : CSR_W) + 1;
   localparam int RESET_SLOTS = (CSR_RESET > MAX_SLOTS) ? MAX_SLOTS : CSR_RESET;

   // Clamped slot count, kept ready to use by the store.
   logic [CNT_W-1:0] slots_ff;
   logic [CNT_W-1:0] slots_in;
   logic [CMP_W-1:0] csr_wide;

   always_comb begin
      csr_wide = CMP_W'(csr_entries_in_use);
      slots_in = slots_ff;
      if (csr_write_enable) begin
         priority if (csr_wide == '0) begin
            slots_in = CNT_W'(1);
         end else if (csr_wide > CMP_W'(MAX_SLOTS)) begin
            slots_in = CNT_W'(MAX_SLOTS);
         end else begin
            slots_in = CNT_W'(csr_wide);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= CNT_W'(RESET_SLOTS);
      end else begin
         slots_ff <= slots_in;
      end
   end

   // Page field taken from the request word.
   logic [PAGE_WIDTH-1:0] req_page;
   if (PAGE_WIDTH <= PAGE_NUMBER_W) begin : g_page_narrow
      assign req_page = req_page_number[PAGE_WIDTH-1:0];
   end else begin : g_page_wide
      assign req_page = {{(PAGE_WIDTH - PAGE_NUMBER_W){1'b0}}, req_page_number};
   end

   // Input register. The store works on it once the output register can take
   // the response, which lets a new request word in during that same cycle.
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [PAGE_WIDTH-1:0] in_page_ff;
   logic                  advance;

   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_page_ff <= req_page;
      end
   end

   logic store_hit;

   lrupr_store #(
      .MAX_SLOTS  (MAX_SLOTS),
      .PAGE_WIDTH (PAGE_WIDTH),
      .CNT_W      (CNT_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .update     (advance),
      .page       (in_page_ff),
      .slots_used (slots_ff),
      .hit        (store_hit)
   );

   // Fault counter. It changes only when a response is loaded, so it doubles as
   // the response's fault total.
   logic [FAULT_W-1:0] fault_ff;
   logic [FAULT_W-1:0] fault_in;

   always_comb begin
      fault_in = fault_ff;
      if (advance && !store_hit && (fault_ff != '1)) begin
         fault_in = fault_ff + FAULT_W'(1);
      end
   end

   // Output register.
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_hit_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff <= store_hit;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_fault_total = fault_ff;

   // The fault total never goes down outside reset.
   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fault_ff >= $past(fault_ff))
      else $error("fault total decreased");

   // A miss below saturation adds exactly one fault.
   a_miss_counts: assert property (@(posedge clock) disable iff (reset)
      advance && !store_hit && (fault_ff != '1) |=> fault_ff == $past(fault_ff) + FAULT_W'(1))
      else $error("miss did not add one fault");

   // A hit leaves the fault total alone and reports a hit.
   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      advance && store_hit |=> $stable(fault_ff) && rsp_hit && rsp_valid)
      else $error("hit changed the fault total or was not reported");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for lru_page_replacement_top: page references go in,
// hit flags and fault totals come out and are checked against a predictor.
// Depends on lrupr_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module tb;

   import lrupr_pkg::*;

   localparam int SLOTS = MAX_SLOTS_DEF;

   // One expected response word: the hit flag and the running fault total.
   typedef struct packed {
      logic               hit;
      logic [FAULT_W-1:0] faults;
   } page_reply_type;

   logic                     clock              = 1'b0;
   logic                     reset              = 1'b1;
   logic                     req_valid          = 1'b0;
   logic                     req_ready;
   logic [PAGE_NUMBER_W-1:0] req_page_number    = '0;
   logic                     rsp_valid;
   logic                     rsp_ready          = 1'b0;
   logic                     rsp_hit;
   logic [FAULT_W-1:0]       rsp_fault_total;
   logic                     csr_write_enable   = 1'b0;
   logic [CSR_W-1:0]         csr_entries_in_use = CSR_W'(CSR_RESET);

   lru_page_replacement_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_page_number    (req_page_number),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_fault_total    (rsp_fault_total),
      .csr_write_enable   (csr_write_enable),
      .csr_entries_in_use (csr_entries_in_use)
   );

   // 4 ns clock period.
   always #2 clock = ~clock;

   // Our own copy of the replacement state. Slot 0 holds the least recently
   // used page, the last valid slot the most recently used one.
   logic [PAGE_NUMBER_W-1:0] lru_pages [SLOTS];
   bit                       lru_valid [SLOTS];
   logic [FAULT_W-1:0]       lru_faults;
   logic [CSR_W-1:0]         lru_slot_count;

   // Responses still owed by the block, oldest first.
   page_reply_type pending_replies [$];

   // Idle behavior: percentage chance that a side pauses before its next word,
   // and a long receiver hold-off that the pressure test can request.
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int long_hold_cycles  = 0;

   int refs_sent     = 0;
   int replies_seen  = 0;
   int hits_seen     = 0;
   int slot_writes   = 0;
   int mismatches    = 0;

   // Most pauses come from the shorter of two ranges; about one in ten is long.
   function automatic int pick_gap(input int idle_pct);
      if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(30, 8);
      return $urandom_range(3, 1);
   endfunction

   // Applies one page reference to the predicted state and queues the
   // response word that the block has to return for it.
   function automatic void predict_reference(input logic [PAGE_NUMBER_W-1:0] page);
      int             used;
      int             hit_at;
      int             free_at;
      int             j;
      page_reply_type reply;
      // A count of zero behaves as one slot, anything above the depth as the
      // full depth. Slots above the count are neither searched nor moved.
      used = int'(lru_slot_count);
      if (used < 1) used = 1;
      if (used > SLOTS) used = SLOTS;
      hit_at  = -1;
      free_at = -1;
      for (int i = 0; i < used; i++) begin
         if (hit_at < 0 && lru_valid[i] && lru_pages[i] == page) hit_at = i;
      end
      if (hit_at >= 0) begin
         // Valid entries after the hit move down one place, stopping at the last
         // slot in use or the first empty slot; the page takes the position freed last.
         j = hit_at;
         while (j + 1 < used && lru_valid[j + 1]) begin
            lru_pages[j] = lru_pages[j + 1];
            j++;
         end
         lru_pages[j] = page;
         lru_valid[j] = 1'b1;
      end else begin
         if (lru_faults != '1) lru_faults++;
         for (int i = 0; i < used; i++) begin
            if (free_at < 0 && !lru_valid[i]) free_at = i;
         end
         if (free_at >= 0) begin
            lru_pages[free_at] = page;
            lru_valid[free_at] = 1'b1;
         end else begin
            // Store full: drop the oldest page, the new one goes last.
            for (int i = 0; i + 1 < used; i++) lru_pages[i] = lru_pages[i + 1];
            lru_pages[used - 1] = page;
            lru_valid[used - 1] = 1'b1;
         end
      end
      reply.hit    = (hit_at >= 0);
      reply.faults = lru_faults;
      pending_replies.push_back(reply);
   endfunction

   // Offers one request word, after an optional pause, and holds it until the
   // block takes it. The prediction is made at the accepting edge.
   task automatic send_page(input logic [PAGE_NUMBER_W-1:0] page);
      int gap;
      gap = pick_gap(sender_idle_pct);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_page_number = page;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_reference(page);
      refs_sent++;
   endtask

   // Stops offering words, waits until every owed response has come back, and
   // then lets the pipeline settle.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the slot-count register; only ever done with the block idle.
   task automatic write_slot_count(input logic [CSR_W-1:0] count);
      wait_until_idle();
      @(negedge clock);
      csr_write_enable   = 1'b1;
      csr_entries_in_use = count;
      @(negedge clock);
      csr_write_enable = 1'b0;
      lru_slot_count   = count;
      slot_writes++;
   endtask

   // Receiver: random pauses of random length, plus a long hold-off when one
   // is requested. The hold-off is counted down here, one cycle at a time.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            rsp_ready = 1'b0;
            long_hold_cycles--;
         end else if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            stall     = pick_gap(receiver_idle_pct);
            rsp_ready = (stall == 0);
            if (stall > 0) stall--;
         end
      end
   end

   // Response checker: every accepted word is compared with the oldest
   // expectation. A word with nothing outstanding is a failure as well.
   initial begin
      page_reply_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            replies_seen++;
            if (rsp_hit) hits_seen++;
            if (pending_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] response word with none outstanding: hit=%0b faults=%0d",
                           $realtime, rsp_hit, rsp_fault_total);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_hit !== want.hit || rsp_fault_total !== want.faults) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("[%0t] mismatch: hit exp %0b got %0b, faults exp %0d got %0d",
                              $realtime, want.hit, rsp_hit, want.faults, rsp_fault_total);
               end
            end
         end
      end
   end

   // Opening references at the reset slot count: both page extremes, alternating
   // bit patterns, a hit in the middle with valid entries after it, a hit on
   // the entry right before an empty slot, a repeat of the newest page and a
   // hit on the oldest one.
   task automatic test_basic_references();
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'hAAAA);
      send_page(16'h5555);
      send_page(16'hFFFF);
      send_page(16'h5555);
      send_page(16'h5555);
      send_page(16'h0000);
   endtask

   // A count of zero must behave as one slot; then the count is one for real.
   // With a single slot every new page evicts the previous one.
   task automatic test_single_slot();
      write_slot_count(CSR_W'(0));
      send_page(16'h1234);
      send_page(16'h1234);
      send_page(16'hAAAA);
      write_slot_count(CSR_W'(1));
      send_page(16'h8000);
      send_page(16'h8000);
   endtask

   // A count above the depth acts as the full depth. Then the store shrinks
   // to two slots, which fill and evict, and grows back so that the slots left
   // alone in between take part again with their old pages.
   task automatic test_shrink_and_raise();
      write_slot_count(CSR_W'(31));
      send_page(16'hFFFF);
      send_page(16'h0001);
      write_slot_count(CSR_W'(2));
      send_page(16'h0002);
      send_page(16'h0003);
      send_page(16'h0002);
      write_slot_count(CSR_W'(16));
      send_page(16'h5555);
      send_page(16'h0000);
      send_page(16'h0003);
   endtask

   // One phase of random traffic at one slot count. Most references come from
   // a small working set a bit larger than the store, so hits, reordering and
   // eviction all happen often; the rest are arbitrary page numbers.
   task automatic run_random_phase(input logic [CSR_W-1:0] count, input int refs,
                                   input int send_pct, input int recv_pct);
      logic [PAGE_NUMBER_W-1:0] working_set [20];
      int                       set_size;
      int                       used;
      logic [PAGE_NUMBER_W-1:0] page;
      write_slot_count(count);
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      used = int'(count);
      if (used < 1) used = 1;
      if (used > SLOTS) used = SLOTS;
      set_size = used + $urandom_range(3, 1);
      for (int i = 0; i < set_size; i++) working_set[i] = PAGE_NUMBER_W'($urandom);
      for (int k = 0; k < refs; k++) begin
         if ($urandom_range(99) < 75)
            page = working_set[$urandom_range(set_size - 1)];
         else
            page = PAGE_NUMBER_W'($urandom);
         send_page(page);
      end
   endtask

   // Random traffic over a spread of slot counts, including both extremes and
   // the out-of-range values, with idling from none at all to heavy.
   task automatic test_random_traffic();
      run_random_phase(CSR_W'(16), 40, 0, 0);
      run_random_phase(CSR_W'(1), 30, 20, 20);
      run_random_phase(CSR_W'(8), 40, 40, 10);
      run_random_phase(CSR_W'(0), 20, 10, 40);
      run_random_phase(CSR_W'(31), 40, 30, 30);
      run_random_phase(CSR_W'(4), 40, 0, 50);
      run_random_phase(CSR_W'(2), 30, 50, 0);
      run_random_phase(CSR_W'(16), 40, 15, 15);
      run_random_phase(CSR_W'(15), 40, 25, 25);
      run_random_phase(CSR_W'(20), 30, 0, 0);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // words back to back, so the pipeline fills and the block stalls its input.
   task automatic test_output_backpressure();
      write_slot_count(CSR_W'(6));
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      long_hold_cycles  = 300;
      for (int k = 0; k < 40; k++) send_page(PAGE_NUMBER_W'($urandom_range(9)));
      receiver_idle_pct = 20;
      for (int k = 0; k < 20; k++) send_page(PAGE_NUMBER_W'($urandom_range(9)));
   endtask

   // Run limit, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      lru_faults     = '0;
      lru_slot_count = CSR_W'(CSR_RESET);
      for (int i = 0; i < SLOTS; i++) begin
         lru_pages[i] = '0;
         lru_valid[i] = 1'b0;
      end

      // Synchronous reset is held at the start and released at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_references();
      test_single_slot();
      test_shrink_and_raise();
      test_random_traffic();
      test_output_backpressure();

      wait_until_idle();
      repeat (8) @(posedge clock);

      $display("Covered %0d page references and %0d response words (%0d hits, %0d faults)",
               refs_sent, replies_seen, hits_seen, replies_seen - hits_seen);
      $display("over %0d slot-count settings, including zero, one, full depth and beyond.",
               slot_writes + 1);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### lru_page_replacement_top.f
design/lrupr_pkg.sv
design/lrupr_store.sv
design/lru_page_replacement_top.sv
tb/tb.sv
